/* hdl/fhp_pkg.sv */
// Shared types and constants of the fragment header parser.
// Depends on nothing; every other file of the block but fhp_if imports it.
package fhp_pkg;

	localparam int HDR_BYTES = 32;
	localparam int HDR_W     = 8 * HDR_BYTES;
	localparam int CNT_W     = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAGS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DGRAM = 3'd6;

	// verdict status codes, in order of checking
	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_SHORT      = 4'd1;
	localparam logic [3:0] ST_LONG       = 4'd2;
	localparam logic [3:0] ST_MAGIC      = 4'd3;
	localparam logic [3:0] ST_VERSION    = 4'd4;
	localparam logic [3:0] ST_TYPE       = 4'd5;
	localparam logic [3:0] ST_HDR_SIZE   = 4'd6;
	localparam logic [3:0] ST_FRAME_ZERO = 4'd7;
	localparam logic [3:0] ST_FRAME_BIG  = 4'd8;
	localparam logic [3:0] ST_COUNT      = 4'd9;
	localparam logic [3:0] ST_INDEX      = 4'd10;
	localparam logic [3:0] ST_PAYLOAD    = 4'd11;
	localparam logic [3:0] ST_FRAME_PL   = 4'd12;
	localparam logic [3:0] ST_LENGTH     = 4'd13;

	typedef struct packed {
		logic [31:0]      magic;
		logic [7:0]       version;
		logic [7:0]       packet_type;
		logic [31:0]      max_frame_bytes;
		logic [15:0]      max_fragments;
		logic [15:0]      max_payload_bytes;
		logic [CNT_W-1:0] max_datagram_bytes;
	} cfg_regs_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [3:0]  status;
		logic [31:0] session_id;
		logic [31:0] frame_id;
		logic [31:0] timestamp_ms;
		logic [31:0] frame_bytes;
		logic [15:0] fragment_index;
		logic [15:0] fragment_count;
		logic [15:0] payload_bytes;
		logic [15:0] flag_bits;
		logic        last_result;
	} result_t;

endpackage

/* hdl/fhp_if.sv */
// Channel interfaces of the fragment header parser: input bytes, results
// and configuration writes.
interface fhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface fhp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [3:0]  status;
	logic [31:0] session_id;
	logic [31:0] frame_id;
	logic [31:0] timestamp_ms;
	logic [31:0] frame_bytes;
	logic [15:0] fragment_index;
	logic [15:0] fragment_count;
	logic [15:0] payload_bytes;
	logic [15:0] flag_bits;
	logic        last_result;

	modport source (output valid, kind, payload_byte, status, session_id, frame_id,
		timestamp_ms, frame_bytes, fragment_index, fragment_count, payload_bytes,
		flag_bits, last_result, input ready);
	modport sink   (input valid, kind, payload_byte, status, session_id, frame_id,
		timestamp_ms, frame_bytes, fragment_index, fragment_count, payload_bytes,
		flag_bits, last_result, output ready);
endinterface

interface fhp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/fhp_cfg.sv */
// Configuration register file of the fragment header parser.
// Depends on fhp_pkg and fhp_cfg_if.
module fhp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	fhp_cfg_if.sink            cfg,
	output fhp_pkg::cfg_regs_t regs
);
	import fhp_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.magic              <= 32'd0;
			regs_q.version            <= 8'd1;
			regs_q.packet_type        <= 8'd1;
			regs_q.max_frame_bytes    <= 32'd4194304;
			regs_q.max_fragments      <= 16'd4096;
			regs_q.max_payload_bytes  <= 16'd1200;
			regs_q.max_datagram_bytes <= 17'd1232;
		end else if (cfg.valid) begin
			// truncate to register width; unknown indexes drop
			unique case (cfg.index)
				CFG_MAGIC:     regs_q.magic              <= cfg.data;
				CFG_VERSION:   regs_q.version            <= cfg.data[7:0];
				CFG_TYPE:      regs_q.packet_type        <= cfg.data[7:0];
				CFG_MAX_FRAME: regs_q.max_frame_bytes    <= cfg.data;
				CFG_MAX_FRAGS: regs_q.max_fragments      <= cfg.data[15:0];
				CFG_MAX_PL:    regs_q.max_payload_bytes  <= cfg.data[15:0];
				CFG_MAX_DGRAM: regs_q.max_datagram_bytes <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

/* hdl/fhp_judge.sv */
// Header checker: builds the end-of-datagram verdict from the captured
// header and the measured length. Depends on fhp_pkg.
module fhp_judge (
	input  logic [fhp_pkg::HDR_W-1:0] hdr,
	input  logic [fhp_pkg::CNT_W-1:0] length,
	input  fhp_pkg::cfg_regs_t        regs,
	output fhp_pkg::result_t          verdict
);
	import fhp_pkg::*;

	logic [31:0] magic, session, frame_id, tstamp, fsize;
	logic [7:0]  version, ptype;
	logic [15:0] hsize, fidx, fcnt, psize, flags;
	logic [3:0]  st;

	assign magic    = hdr[255:224];
	assign version  = hdr[223:216];
	assign ptype    = hdr[215:208];
	assign hsize    = hdr[207:192];
	assign session  = hdr[191:160];
	assign frame_id = hdr[159:128];
	assign tstamp   = hdr[127:96];
	assign fsize    = hdr[95:64];
	assign fidx     = hdr[63:48];
	assign fcnt     = hdr[47:32];
	assign psize    = hdr[31:16];
	assign flags    = hdr[15:0];

	// first failing check wins
	always_comb begin
		if (length < CNT_W'(HDR_BYTES))                      st = ST_SHORT;
		else if (length > regs.max_datagram_bytes)          st = ST_LONG;
		else if (magic != regs.magic)                       st = ST_MAGIC;
		else if (version != regs.version)                   st = ST_VERSION;
		else if (ptype != regs.packet_type)                 st = ST_TYPE;
		else if (hsize != 16'(HDR_BYTES))                   st = ST_HDR_SIZE;
		else if (fsize == 32'd0)                            st = ST_FRAME_ZERO;
		else if (fsize > regs.max_frame_bytes)              st = ST_FRAME_BIG;
		else if (fcnt == 16'd0 || fcnt > regs.max_fragments) st = ST_COUNT;
		else if (fidx >= fcnt)                              st = ST_INDEX;
		else if (psize == 16'd0 || psize > regs.max_payload_bytes) st = ST_PAYLOAD;
		else if (fsize < {16'd0, psize})                    st = ST_FRAME_PL;
		else if (length != CNT_W'(HDR_BYTES) + {1'b0, psize}) st = ST_LENGTH;
		else                                                st = ST_OK;
	end

	always_comb begin
		verdict             = '0;
		verdict.kind        = 1'b1;
		verdict.status      = st;
		verdict.last_result = 1'b1;
		if (st == ST_OK) begin
			verdict.session_id     = session;
			verdict.frame_id       = frame_id;
			verdict.timestamp_ms   = tstamp;
			verdict.frame_bytes    = fsize;
			verdict.fragment_index = fidx;
			verdict.fragment_count = fcnt;
			verdict.payload_bytes  = psize;
			verdict.flag_bits      = flags;
		end
	end
endmodule

/* hdl/fragment_header_parser.sv */
// Top level of the fragment header parser: input register, header capture,
// result register. Depends on fhp_pkg, fhp_if, fhp_cfg and fhp_judge.
//
// Usage
//   in_ch  : one datagram byte per word, last_byte set on its final byte.
//   out_ch : result words. kind 0 carries a payload byte (every byte after
//            the 32-byte header); kind 1 is the verdict closing a datagram,
//            status 0 with the header fields, or a failure code with the
//            header fields at zero.
//   cfg    : register writes, always ready; write only while idle.
// Timing
//   A byte is taken every cycle unless out_ch stalls or a final byte is
//   still handing out its words. Its result word passes from the input
//   register to the result register and then shows on out_ch. A final byte
//   that follows the header yields two words, payload then verdict, so it
//   holds the input register until both are out and the next byte waits.
// Reset
//   Clears the byte counter, the pipeline valids and the registers to their
//   defaults. The header register needs no reset: it only affects a verdict
//   once the whole header of the current datagram has been shifted in.
// Stall
//   When out_ch stalls, the result register holds. A byte that has a word to
//   hand out waits in the input register and in_ch.ready drops until a word
//   leaves; header bytes hand out nothing and keep flowing.
module fragment_header_parser (
	input  logic      clk,
	input  logic      arst_n,
	fhp_in_if.sink    in_ch,
	fhp_out_if.source out_ch,
	fhp_cfg_if.sink   cfg
);
	import fhp_pkg::*;

	cfg_regs_t        regs;
	result_t          verdict;
	result_t          res_next;
	result_t          res_q;
	logic             out_vld_q;

	logic [CNT_W-1:0] count_q;
	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [CNT_W-1:0] pos_s1;
	logic             done_s1;
	logic [HDR_W-1:0] hdr_q;

	logic             accept;
	logic             is_pl;
	logic             emit;
	logic             emit_verdict;
	logic             out_free;
	logic             s1_adv;
	logic             s1_retire;
	logic [CNT_W-1:0] length;
	logic [HDR_W-1:0] hdr_view;

	fhp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// byte belongs to the payload once the header is complete
	assign is_pl        = pos_s1 >= CNT_W'(HDR_BYTES);
	assign emit_verdict = vld_s1 && last_s1 && (!is_pl || done_s1);
	assign emit         = vld_s1 && ((is_pl && !done_s1) || last_s1);
	assign out_free     = !out_vld_q || out_ch.ready;
	// advance one step: hand out one word, or none for a header byte
	assign s1_adv       = vld_s1 && (!emit || out_free);
	assign s1_retire    = s1_adv && (!last_s1 || emit_verdict);
	assign in_ch.ready  = !vld_s1 || s1_retire;
	assign accept       = in_ch.valid && in_ch.ready;

	// measured length saturates with the counter
	assign length   = (pos_s1 == CNT_MAX) ? CNT_MAX : pos_s1 + CNT_W'(1);
	// a final header byte still sits in the input register: include it
	assign hdr_view = is_pl ? hdr_q : {hdr_q[HDR_W-9:0], byte_s1};

	fhp_judge u_judge (
		.hdr     (hdr_view),
		.length  (length),
		.regs    (regs),
		.verdict (verdict)
	);

	always_comb begin
		res_next              = '0;
		res_next.payload_byte = byte_s1;
		if (emit_verdict) begin
			res_next = verdict;
		end
	end

	// byte counter: position of the next accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (in_ch.last_byte) begin
				count_q <= '0;
			end else if (count_q != CNT_MAX) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1  <= 1'b1;
			done_s1 <= 1'b0;
		end else begin
			if (s1_retire) begin
				vld_s1 <= 1'b0;
			end
			// payload word of a final byte is out: verdict next
			if (s1_adv && emit && !emit_verdict) begin
				done_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
			pos_s1  <= count_q;
		end
	end

	// header capture: shift header bytes in, first byte ends up on top
	always_ff @(posedge clk) begin
		if (s1_retire && !is_pl) begin
			hdr_q <= {hdr_q[HDR_W-9:0], byte_s1};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			res_q <= res_next;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.kind           = res_q.kind;
	assign out_ch.payload_byte   = res_q.payload_byte;
	assign out_ch.status         = res_q.status;
	assign out_ch.session_id     = res_q.session_id;
	assign out_ch.frame_id       = res_q.frame_id;
	assign out_ch.timestamp_ms   = res_q.timestamp_ms;
	assign out_ch.frame_bytes    = res_q.frame_bytes;
	assign out_ch.fragment_index = res_q.fragment_index;
	assign out_ch.fragment_count = res_q.fragment_count;
	assign out_ch.payload_bytes  = res_q.payload_bytes;
	assign out_ch.flag_bits      = res_q.flag_bits;
	assign out_ch.last_result    = res_q.last_result;
endmodule

/* dv/tb.sv */
// Self-checking bench for fragment_header_parser: random and directed datagrams in,
// payload and verdict words checked against a cycle-free header predictor.
// Depends on fhp_pkg, the fhp_if channel interfaces and the RTL top level.
module tb;
	import fhp_pkg::*;

	// Percentage of cycles in which either side idles, outside calm stretches
	localparam int IDLE_PCT      = 29;
	// Cycles to let pass once nothing is expected, before touching registers
	localparam int SETTLE_CYCLES = 8;
	// Upper bound on the final drain
	localparam int DRAIN_LIMIT   = 20000;
	// Print at most this many mismatch lines; the rest are only counted
	localparam int MAX_REPORTS   = 50;

	// The one register index the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// One byte of a datagram as the input channel carries it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} dgram_word_t;

	// The 32-byte big-endian header, in wire order: most significant byte first
	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  version;
		logic [7:0]  packet_type;
		logic [15:0] hdr_size;
		logic [31:0] session_id;
		logic [31:0] frame_id;
		logic [31:0] timestamp_ms;
		logic [31:0] frame_bytes;
		logic [15:0] fragment_index;
		logic [15:0] fragment_count;
		logic [15:0] payload_bytes;
		logic [15:0] flag_bits;
	} wire_header_t;

	// Datagram shapes the random generator aims at; each one targets a verdict
	typedef enum int {
		DG_GOOD,
		DG_BAD_MAGIC,
		DG_BAD_VERSION,
		DG_BAD_TYPE,
		DG_BAD_HDR_SIZE,
		DG_FRAME_ZERO,
		DG_FRAME_BIG,
		DG_BAD_COUNT,
		DG_BAD_INDEX,
		DG_BAD_PAYLOAD,
		DG_FRAME_LT_PAYLOAD,
		DG_BAD_LENGTH,
		DG_SHORT,
		DG_LONG,
		DG_NOISE
	} dgram_shape_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Bench-side drive registers; every block input is known from time zero
	logic                  in_valid  = 1'b0;
	logic [7:0]            in_data   = '0;
	logic                  in_last   = 1'b0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Calm: neither side idles while set
	bit calm = 1'b0;

	fhp_in_if  in_ch ();
	fhp_out_if out_ch ();
	fhp_cfg_if cfg_ch ();

	assign in_ch.valid     = in_valid;
	assign in_ch.data_byte = in_data;
	assign in_ch.last_byte = in_last;
	assign out_ch.ready    = out_ready;
	assign cfg_ch.valid    = cfg_valid;
	assign cfg_ch.index    = cfg_index;
	assign cfg_ch.data     = cfg_data;

	fragment_header_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: register copy at its reset values, byte counter and
	// the captured header. Registers are rewritten only while idle.
	// ------------------------------------------------------------------
	cfg_regs_t model_cfg = '{
		magic:              32'd0,
		version:            8'd1,
		packet_type:        8'd1,
		max_frame_bytes:    32'd4194304,
		max_fragments:      16'd4096,
		max_payload_bytes:  16'd1200,
		max_datagram_bytes: 17'd1232
	};
	logic [CNT_W-1:0] byte_cnt = '0;
	logic [7:0]       hdr_seen [HDR_BYTES];

	dgram_word_t pending_bytes [$];
	result_t     expected_results [$];

	int unsigned words_queued    = 0;
	int unsigned words_in        = 0;
	int unsigned results_checked = 0;
	int unsigned verdicts        = 0;
	int unsigned settings_used   = 0;
	int unsigned err_cnt         = 0;

	// Big-endian read of up to four captured header bytes
	function automatic logic [31:0] hdr_field(int unsigned pos, int unsigned len);
		logic [31:0] v;
		v = '0;
		for (int unsigned i = 0; i < len; i++)
			v = {v[23:0], hdr_seen[pos + i]};
		return v;
	endfunction

	// Verdict of a finished datagram; the first failing check wins
	function automatic logic [3:0] judge_datagram(logic [CNT_W-1:0] len);
		logic [31:0] fsize;
		logic [15:0] fidx, fcnt, psize;
		if (len < CNT_W'(HDR_BYTES)) return ST_SHORT;
		if (len > model_cfg.max_datagram_bytes) return ST_LONG;
		if (hdr_field(0, 4) != model_cfg.magic) return ST_MAGIC;
		if (8'(hdr_field(4, 1)) != model_cfg.version) return ST_VERSION;
		if (8'(hdr_field(5, 1)) != model_cfg.packet_type) return ST_TYPE;
		if (16'(hdr_field(6, 2)) != 16'(HDR_BYTES)) return ST_HDR_SIZE;
		fsize = hdr_field(20, 4);
		fidx  = 16'(hdr_field(24, 2));
		fcnt  = 16'(hdr_field(26, 2));
		psize = 16'(hdr_field(28, 2));
		if (fsize == '0) return ST_FRAME_ZERO;
		if (fsize > model_cfg.max_frame_bytes) return ST_FRAME_BIG;
		if (fcnt == '0 || fcnt > model_cfg.max_fragments) return ST_COUNT;
		if (fidx >= fcnt) return ST_INDEX;
		if (psize == '0 || psize > model_cfg.max_payload_bytes) return ST_PAYLOAD;
		if (fsize < {16'd0, psize}) return ST_FRAME_PL;
		if (len != CNT_W'(HDR_BYTES) + {1'b0, psize}) return ST_LENGTH;
		return ST_OK;
	endfunction

	// Advance the predictor by one accepted byte and queue what it causes
	function automatic void predict_word(logic [7:0] b, logic last);
		result_t          r;
		logic [CNT_W-1:0] pos, len;
		pos = byte_cnt;
		if (pos < CNT_W'(HDR_BYTES)) begin
			hdr_seen[pos[4:0]] = b;
		end else begin
			// every byte past the header is passed straight out
			r = '0;
			r.kind = KIND_PAYLOAD;
			r.payload_byte = b;
			expected_results.push_back(r);
		end
		// the counter sticks at its top value on very long datagrams
		len = (pos != CNT_MAX) ? pos + CNT_W'(1) : CNT_MAX;
		byte_cnt = len;
		if (last) begin
			r = '0;
			r.kind = KIND_VERDICT;
			r.status = judge_datagram(len);
			r.last_result = 1'b1;
			// header fields are only reported on success
			if (r.status == ST_OK) begin
				r.session_id     = hdr_field(8, 4);
				r.frame_id       = hdr_field(12, 4);
				r.timestamp_ms   = hdr_field(16, 4);
				r.frame_bytes    = hdr_field(20, 4);
				r.fragment_index = 16'(hdr_field(24, 2));
				r.fragment_count = 16'(hdr_field(26, 2));
				r.payload_bytes  = 16'(hdr_field(28, 2));
				r.flag_bits      = 16'(hdr_field(30, 2));
			end
			expected_results.push_back(r);
			byte_cnt = '0;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				results_checked, name, got, want));
	endtask

	// Compare one result word with the oldest expectation
	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result word with nothing expected, kind %0d status %0d",
				got.kind, got.status));
			return;
		end
		want = expected_results.pop_front();
		cmp_field("kind", 32'(got.kind), 32'(want.kind));
		cmp_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
		cmp_field("status", 32'(got.status), 32'(want.status));
		cmp_field("session_id", got.session_id, want.session_id);
		cmp_field("frame_id", got.frame_id, want.frame_id);
		cmp_field("timestamp_ms", got.timestamp_ms, want.timestamp_ms);
		cmp_field("frame_bytes", got.frame_bytes, want.frame_bytes);
		cmp_field("fragment_index", 32'(got.fragment_index), 32'(want.fragment_index));
		cmp_field("fragment_count", 32'(got.fragment_count), 32'(want.fragment_count));
		cmp_field("payload_bytes", 32'(got.payload_bytes), 32'(want.payload_bytes));
		cmp_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
		cmp_field("last_result", 32'(got.last_result), 32'(want.last_result));
		results_checked++;
		if (want.kind == KIND_VERDICT)
			verdicts++;
	endtask

	// ------------------------------------------------------------------
	// Driver: pop a word on acceptance and feed it to the predictor, then
	// hold a stalled word, or offer the next one unless this cycle idles.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (in_valid && in_ch.ready) begin
			predict_word(in_data, in_last);
			void'(pending_bytes.pop_front());
			words_in++;
		end
		if (!in_valid || in_ch.ready) begin
			if (arst_n && pending_bytes.size() != 0 &&
			    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				in_data  <= pending_bytes[0].data;
				in_last  <= pending_bytes[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check every accepted result word, then roll the next ready.
	// Ready may drop at any time; the block must hold its word meanwhile.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (out_ready && out_ch.valid)
			check_result({out_ch.kind, out_ch.payload_byte, out_ch.status, out_ch.session_id,
				out_ch.frame_id, out_ch.timestamp_ms, out_ch.frame_bytes, out_ch.fragment_index,
				out_ch.fragment_count, out_ch.payload_bytes, out_ch.flag_bits,
				out_ch.last_result});
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_word(input logic [7:0] data, input logic last);
		pending_bytes.push_back('{data: data, last: last});
		words_queued++;
	endtask

	// A datagram of n random bytes, no header structure at all
	task automatic queue_raw(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			push_word(8'($urandom_range(0, 255)), i == n - 1);
	endtask

	// Header in wire order followed by body random payload bytes
	task automatic queue_frame(input wire_header_t h, input int unsigned body);
		logic [HDR_W-1:0] flat;
		int unsigned      total;
		flat  = h;
		total = HDR_BYTES + body;
		for (int unsigned i = 0; i < total; i++)
			push_word(i < HDR_BYTES ? flat[HDR_W - 1 - 8 * i -: 8] :
				8'($urandom_range(0, 255)), i == total - 1);
	endtask

	// Build one random datagram against setting c: about half well formed,
	// the rest broken in one targeted field, cut short, overlong or noise
	task automatic queue_datagram(input cfg_regs_t c);
		wire_header_t h;
		dgram_shape_t shape;
		int unsigned  cap, body, pick, dmax;
		// keep payloads small, and fit them under every limit where possible
		dmax = 32'(c.max_datagram_bytes);
		cap = 12;
		if (32'(c.max_payload_bytes) < cap) cap = 32'(c.max_payload_bytes);
		if (c.max_frame_bytes < cap) cap = c.max_frame_bytes;
		if (dmax > HDR_BYTES && dmax - HDR_BYTES < cap)
			cap = dmax - HDR_BYTES;
		if (cap == 0) cap = 1;

		h.magic          = c.magic;
		h.version        = c.version;
		h.packet_type    = c.packet_type;
		h.hdr_size       = 16'(HDR_BYTES);
		h.session_id     = $urandom;
		h.frame_id       = $urandom;
		h.timestamp_ms   = $urandom;
		h.flag_bits      = 16'($urandom);
		h.payload_bytes  = 16'($urandom_range(1, cap));
		// lean on the frame size boundaries now and then
		case ($urandom_range(0, 3))
			0: h.frame_bytes = 32'(h.payload_bytes);
			1: h.frame_bytes = c.max_frame_bytes;
			default: h.frame_bytes = 32'(h.payload_bytes) +
				$urandom_range(0, c.max_frame_bytes - 32'(h.payload_bytes));
		endcase
		h.fragment_count = 16'($urandom_range(1, 32'(c.max_fragments)));
		h.fragment_index = 16'($urandom_range(0, 32'(h.fragment_count) - 1));
		body = 32'(h.payload_bytes);

		pick  = $urandom_range(0, 27);
		shape = (pick <= DG_NOISE) ? dgram_shape_t'(pick) : DG_GOOD;
		case (shape)
			DG_BAD_MAGIC:    h.magic ^= 32'h1 << $urandom_range(0, 31);
			DG_BAD_VERSION:  h.version ^= 8'h1 << $urandom_range(0, 7);
			DG_BAD_TYPE:     h.packet_type ^= 8'h1 << $urandom_range(0, 7);
			DG_BAD_HDR_SIZE: h.hdr_size ^= 16'h1 << $urandom_range(0, 15);
			DG_FRAME_ZERO:   h.frame_bytes = '0;
			DG_FRAME_BIG: begin
				if (c.max_frame_bytes != '1)
					h.frame_bytes = $urandom_range(c.max_frame_bytes + 1, 32'hFFFF_FFFF);
			end
			DG_BAD_COUNT: begin
				if (c.max_fragments == '1 || $urandom_range(0, 1))
					h.fragment_count = '0;
				else
					h.fragment_count = 16'($urandom_range(32'(c.max_fragments) + 1,
						32'hFFFF));
				h.fragment_index = '0;
			end
			DG_BAD_INDEX: h.fragment_index = 16'($urandom_range(32'(h.fragment_count),
				32'hFFFF));
			DG_BAD_PAYLOAD: begin
				if (c.max_payload_bytes == '1 || $urandom_range(0, 1))
					h.payload_bytes = '0;
				else
					h.payload_bytes = 16'($urandom_range(32'(c.max_payload_bytes) + 1,
						32'hFFFF));
				body = $urandom_range(0, 6);
			end
			DG_FRAME_LT_PAYLOAD: begin
				h.payload_bytes = 16'($urandom_range(2, (cap < 2) ? 2 : cap));
				h.frame_bytes   = $urandom_range(1, 32'(h.payload_bytes) - 1);
				body = 32'(h.payload_bytes);
			end
			DG_BAD_LENGTH: begin
				if ($urandom_range(0, 1))
					body = 32'(h.payload_bytes) - 1;
				else
					body = 32'(h.payload_bytes) + $urandom_range(1, 3);
			end
			DG_LONG: begin
				// only cheap when the datagram limit is small
				if (dmax <= 96)
					body = dmax - HDR_BYTES + $urandom_range(1, 3);
				else
					body = body + 1;
			end
			DG_NOISE: begin
				h = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
				body = $urandom_range(0, 8);
			end
			default: ;
		endcase

		if (shape == DG_SHORT)
			queue_raw($urandom_range(1, HDR_BYTES - 1));
		else
			queue_frame(h, body);
	endtask

	// Wait until every byte is in and every result out, then let the
	// pipeline settle before registers change
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mask a register value to its width and fill the unused bits with junk
	function automatic logic [31:0] pad_junk(logic [31:0] v, int w);
		logic [31:0] mask;
		mask = (w >= 32) ? '1 : ((32'h1 << w) - 32'h1);
		return (v & mask) | ($urandom & ~mask);
	endfunction

	// One register write; valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_MAGIC:     model_cfg.magic              = data;
			CFG_VERSION:   model_cfg.version            = data[7:0];
			CFG_TYPE:      model_cfg.packet_type        = data[7:0];
			CFG_MAX_FRAME: model_cfg.max_frame_bytes    = data;
			CFG_MAX_FRAGS: model_cfg.max_fragments      = data[15:0];
			CFG_MAX_PL:    model_cfg.max_payload_bytes  = data[15:0];
			CFG_MAX_DGRAM: model_cfg.max_datagram_bytes = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Write a whole setting, poke the undecoded index, then drop valid
	task automatic program_regs(input cfg_regs_t c);
		write_reg(CFG_MAGIC, c.magic);
		write_reg(CFG_VERSION, pad_junk(32'(c.version), 8));
		write_reg(CFG_TYPE, pad_junk(32'(c.packet_type), 8));
		write_reg(CFG_MAX_FRAME, c.max_frame_bytes);
		write_reg(CFG_SPARE, $urandom);
		write_reg(CFG_MAX_FRAGS, pad_junk(32'(c.max_fragments), 16));
		write_reg(CFG_MAX_PL, pad_junk(32'(c.max_payload_bytes), 16));
		write_reg(CFG_MAX_DGRAM, pad_junk(32'(c.max_datagram_bytes), CNT_W));
		cfg_valid <= 1'b0;
	endtask

	// Program a setting, then run random datagrams until n_bytes are queued
	task automatic run_phase(input cfg_regs_t c, input int unsigned n_bytes);
		int unsigned mark;
		program_regs(c);
		settings_used++;
		mark = words_queued;
		while (words_queued - mark < n_bytes)
			queue_datagram(c);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_regs_t    c;
		wire_header_t h;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset setting with no writes at all
		settings_used = 1;
		// shortest datagram, and the longest that is still too short
		queue_raw(1);
		queue_raw(HDR_BYTES - 1);
		// smallest good frame, session, frame, time and flag fields all ones
		h = '{magic: model_cfg.magic, version: model_cfg.version,
			packet_type: model_cfg.packet_type, hdr_size: 16'(HDR_BYTES),
			session_id: '1, frame_id: '1, timestamp_ms: '1, frame_bytes: 32'd1,
			fragment_index: '0, fragment_count: 16'd1, payload_bytes: 16'd1, flag_bits: '1};
		queue_frame(h, 1);
		// frame and fragment limits met exactly, last fragment
		h.session_id     = '0;
		h.frame_id       = '0;
		h.timestamp_ms   = '0;
		h.flag_bits      = '0;
		h.frame_bytes    = model_cfg.max_frame_bytes;
		h.fragment_count = model_cfg.max_fragments;
		h.fragment_index = model_cfg.max_fragments - 16'd1;
		h.payload_bytes  = 16'd8;
		queue_frame(h, 32'(h.payload_bytes));
		// header alone: the final byte lands inside the header
		h.payload_bytes = '0;
		queue_frame(h, 0);
		wait_idle();

		// Low extremes: nothing can pass the datagram length limit
		c = '{magic: '0, version: '0, packet_type: '0, max_frame_bytes: 32'd1,
			max_fragments: 16'd1, max_payload_bytes: 16'd1,
			max_datagram_bytes: CNT_W'(HDR_BYTES)};
		run_phase(c, 120);

		// High extremes, with a long stretch in which neither side idles
		c = '{magic: '1, version: '1, packet_type: '1, max_frame_bytes: '1,
			max_fragments: '1, max_payload_bytes: '1, max_datagram_bytes: 17'd65567};
		calm = 1'b1;
		run_phase(c, 160);
		calm = 1'b0;

		// Tight limits, so that every size check fires now and then
		c.magic              = $urandom;
		c.version            = 8'($urandom_range(0, 255));
		c.packet_type        = 8'($urandom_range(0, 255));
		c.max_frame_bytes    = $urandom_range(1, 64);
		c.max_fragments      = 16'($urandom_range(1, 8));
		c.max_payload_bytes  = 16'($urandom_range(2, 16));
		c.max_datagram_bytes = CNT_W'($urandom_range(34, 48));
		run_phase(c, 190);

		// Random limits across the register widths, the datagram limit up to 65567
		c.magic              = $urandom;
		c.version            = 8'($urandom_range(0, 255));
		c.packet_type        = 8'($urandom_range(0, 255));
		c.max_frame_bytes    = $urandom_range(1, 32'hFFFF_FFFF);
		c.max_fragments      = 16'($urandom_range(1, 32'hFFFF));
		c.max_payload_bytes  = 16'($urandom_range(1, 32'hFFFF));
		c.max_datagram_bytes = CNT_W'($urandom_range(HDR_BYTES, 65567));
		run_phase(c, 160);

		// Drain whatever is left, bounded
		for (int n = 0; n < DRAIN_LIMIT &&
		     (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0); n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d expected result words never arrived",
				expected_results.size()));

		$display("%0d bytes in, %0d result words checked, %0d of them verdicts,",
			words_in, results_checked, verdicts);
		$display("over %0d register settings, short, long and boundary datagrams included",
			settings_used);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hard stop, well past the slowest correct run
	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
